// ===== src/alp_pkg.sv =====
// shared constants, types and state codes of the loop player
`default_nettype none

package alp_pkg;

  // sample store geometry (depth is a power of two)
  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // field widths
  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int SG_W       = 32;
  localparam int CC_W       = 2;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 3 * SAMPLE_W;
  localparam int OUT_DATA_W = 2 * SAMPLE_W;

  // fade ramp (length is a power of two)
  localparam int RAMP_LENGTH = 256;
  localparam int RAMP_W      = $clog2(RAMP_LENGTH + 1);
  localparam int RAMP_SHIFT  = $clog2(RAMP_LENGTH);

  // scaled sample before fade, q1.15 times q2.30 rounded back to q.15
  localparam int LV_W     = SAMPLE_W + 2;
  localparam int SCALE_SH = SG_W - 2;

  // gain smoothing divider, radix 16 long division by a constant
  localparam int DIV_RADIX_W = 4;
  localparam int DIVIDEND_W  = 36;
  localparam int DIV_STEPS   = DIVIDEND_W / DIV_RADIX_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
  localparam int GAIN_DEN    = 1000;
  localparam int GAIN_HALF   = 500;
  localparam int DIV_REM_W   = $clog2(GAIN_DEN);
  localparam int DIV_T_W     = DIV_REM_W + DIV_RADIX_W;
  localparam int GAIN_BIAS_SH = 23;
  localparam logic [DIVIDEND_W-1:0] QUO_BIAS    = DIVIDEND_W'(1) << GAIN_BIAS_SH;
  localparam logic [DIVIDEND_W-1:0] GAIN_OFFSET = DIVIDEND_W'(GAIN_DEN) << GAIN_BIAS_SH;

  // request kinds on the input stream
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_TICK = 2'd1,
    OP_SEEK = 2'd2
  } op_e;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_ENABLE = 3'd5;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_RIGHT,
    ST_CAP_RIGHT,
    ST_GAIN_WAIT,
    ST_MUL_LEFT,
    ST_MUL_RIGHT,
    ST_FADE_RIGHT,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ===== src/alp_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none

module alp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/alp_gain_div.sv =====
// radix 16 long division of the gain smoothing sum by a constant
`default_nettype none

module alp_gain_div
  import alp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t    rsp_o
);

  logic [DIVIDEND_W-1:0]  dvd_q, quo_q;
  logic [DIV_REM_W-1:0]   rem_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic                   done_q;
  logic [DIV_T_W-1:0]     trial;
  logic [DIV_RADIX_W-1:0] digit;
  logic [DIV_T_W-1:0]     sub;

  // pick the largest multiple of the divisor that fits
  always_comb begin
    trial = {rem_q, dvd_q[DIVIDEND_W-1 -: DIV_RADIX_W]};
    digit = '0;
    sub   = '0;
    for (int k = 1; k < (1 << DIV_RADIX_W); k++) begin
      if (trial >= DIV_T_W'(k * GAIN_DEN)) begin
        digit = DIV_RADIX_W'(k);
        sub   = DIV_T_W'(k * GAIN_DEN);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= DIV_CNT_W'(DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      dvd_q <= dvd_q << DIV_RADIX_W;
      rem_q <= DIV_REM_W'(trial - sub);
      quo_q <= {quo_q[DIVIDEND_W-DIV_RADIX_W-1:0], digit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/audio_loop_player.sv =====
// loop player top level: request decode, sample store, gain, fade and output
`default_nettype none

// channel    dir   handshake                  payload
// s_axis     in    s_axis_tvalid/tready       tuser op, tdata address/sample/seek
// m_axis     out   m_axis_tvalid/tready       tdata left/right, tuser wrap flag
// cfg        in    cfg_valid/cfg_ready        cfg_index, cfg_data (always ready)
//
// load and seek requests finish in idle, a tick with play off goes straight
// to emit; a playing tick waits on the 9 step gain divider that runs beside
// the two sample reads, then takes two shared multiplier passes
// reset clears position, smoothed gain, ramp and state and presets config; the
// sample store itself is not cleared and must be loaded before it is played
// the result sits in an output register, so a new request is taken while it
// waits; a tick result only stalls the block when the previous one is unread

module audio_loop_player
  import alp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: load_address[15:0], load_sample[31:16], seek_position[47:32]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op[1:0]
  input  wire logic [OP_W-1:0]       s_axis_tuser_i,
  // output stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // tdata: left_out[15:0], right_out[31:16]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // tuser: loop_wrapped[0]
  output logic [0:0]                 m_axis_tuser_o,
  // configuration writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CMP_W   = POS_W + 2;
  localparam int SCALE_W = SAMPLE_W + SG_W + 1;
  localparam int FPROD_W = LV_W + RAMP_W + 1;
  localparam logic signed [CMP_W-1:0] RL_EXT = CMP_W'(RAMP_LENGTH);

  state_e state_q, state_d;

  // configuration registers
  logic [POS_W-1:0]  loop_start_q, loop_end_q;
  logic [GAIN_W-1:0] target_gain_q;
  logic [CC_W-1:0]   chan_count_q;
  logic              reverse_q, play_q;

  // architectural state
  logic [POS_W-1:0]  pos_q;
  logic [SG_W-1:0]   sg_q;
  logic [RAMP_W-1:0] ramp_q;

  // per tick working registers
  logic [SAMPLE_W-1:0]     lw_q, rw_q, lf_q, rf_q;
  logic signed [LV_W-1:0]  lv_q, rv_q;
  logic                    wrap_q, fade_q;

  // output register
  logic                  out_valid_q;
  logic [SAMPLE_W-1:0]   out_l_q, out_r_q;
  logic                  out_wrap_q;

  // request fields
  logic              in_acc;
  logic [OP_W-1:0]   in_op;
  logic [POS_W-1:0]  in_addr, in_seek;
  logic [SAMPLE_W-1:0] in_sample;
  logic              out_free;

  // control strobes
  logic              mem_we, mem_re, rd_right, div_start, emit;

  assign in_op     = s_axis_tuser_i;
  assign in_addr   = s_axis_tdata_i[SAMPLE_W-1:0];
  assign in_sample = s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W];
  assign in_seek   = s_axis_tdata_i[3*SAMPLE_W-1:2*SAMPLE_W];
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  // frame addressing: stride 1, 2 or 3 words per frame
  logic [CMP_W-1:0]  pos_ext, frame_base;
  logic              stereo;
  logic [MEM_AW-1:0] left_addr, right_addr, mem_raddr;
  logic [SAMPLE_W-1:0] mem_rdata;

  assign pos_ext = {2'b00, pos_q};
  assign stereo  = chan_count_q[1];

  always_comb begin
    case (chan_count_q)
      2'd2:    frame_base = pos_ext << 1;
      2'd3:    frame_base = (pos_ext << 1) + pos_ext;
      default: frame_base = pos_ext;
    endcase
  end

  assign left_addr  = MEM_AW'(frame_base);
  assign right_addr = MEM_AW'(frame_base + CMP_W'(1));
  assign mem_raddr  = rd_right ? right_addr : left_addr;

  alp_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (MEM_AW'(in_addr)),
    .wdata_i (in_sample),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // gain smoothing: sg' = sg + floor((tg*2^16 - sg + 500) / 1000), biased positive
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [DIVIDEND_W-1:0] sg_sum;
  logic [SG_W-1:0]       sg_next;

  assign div_req.start    = div_start;
  assign div_req.dividend = {{(DIVIDEND_W-GAIN_W-16){1'b0}}, target_gain_q, 16'h0000}
                            + DIVIDEND_W'(GAIN_HALF) + GAIN_OFFSET
                            - {{(DIVIDEND_W-SG_W){1'b0}}, sg_q};

  assign sg_sum  = {{(DIVIDEND_W-SG_W){1'b0}}, sg_q} + div_rsp.quotient - QUO_BIAS;
  assign sg_next = sg_sum[SG_W-1:0];

  alp_gain_div u_gain_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // shared sample scaler, round half up back to q.15
  logic [SAMPLE_W-1:0]       mul_word;
  logic signed [SCALE_W-1:0] scale_prod;
  logic [SCALE_W-1:0]        scale_rnd;
  logic [LV_W-1:0]           scaled;

  assign mul_word   = (state_q == ST_MUL_LEFT) ? lw_q : rw_q;
  assign scale_prod = $signed(mul_word) * $signed({1'b0, sg_q});
  assign scale_rnd  = scale_prod + (SCALE_W'(1) << (SCALE_SH - 1));
  assign scaled     = scale_rnd[SCALE_SH+LV_W-1:SCALE_SH];

  // shared fader, truncation toward zero, then saturation
  logic signed [LV_W-1:0]    fade_src;
  logic signed [FPROD_W-1:0] fprod, fbias, fsum, fdiv, fval;
  logic [SAMPLE_W-1:0]       fsat;

  function automatic logic [SAMPLE_W-1:0] sat16(input logic [FPROD_W-1:0] v);
    logic [FPROD_W-SAMPLE_W:0] hi;
    logic [SAMPLE_W-1:0]       r;
    hi = v[FPROD_W-1:SAMPLE_W-1];
    if ((&hi) || !(|hi)) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[FPROD_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

  assign fade_src = (state_q == ST_MUL_RIGHT) ? lv_q : rv_q;
  assign fprod    = fade_src * $signed({1'b0, ramp_q});
  assign fbias    = fprod[FPROD_W-1] ? FPROD_W'(RAMP_LENGTH - 1) : '0;
  assign fsum     = fprod + fbias;
  assign fdiv     = fsum >>> RAMP_SHIFT;
  assign fval     = fade_q ? fdiv : {{(FPROD_W-LV_W){fade_src[LV_W-1]}}, fade_src};
  assign fsat     = sat16(fval);

  // position step, loop wrap and fade window
  logic [POS_W-1:0]        pos_step;
  logic signed [CMP_W-1:0] p_s, ls_s, le_s, ls_plus, le_minus;
  logic                    past_end, before_start, in_fade_in, in_fade_out;

  assign pos_step = reverse_q ? pos_q - 1'b1 : pos_q + 1'b1;
  assign p_s      = {2'b00, pos_step};
  assign ls_s     = {2'b00, loop_start_q};
  assign le_s     = {2'b00, loop_end_q};
  assign ls_plus  = ls_s + RL_EXT;
  assign le_minus = le_s - RL_EXT;

  assign past_end     = p_s > le_s;
  assign before_start = p_s <= ls_s;
  assign in_fade_in   = reverse_q ? (p_s > le_minus) : (p_s < ls_plus);
  assign in_fade_out  = reverse_q ? (p_s < ls_plus) : (p_s > le_minus);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_op == OP_TICK) begin
          state_d = play_q ? ST_RD_RIGHT : ST_EMIT;
        end
      end
      ST_RD_RIGHT:   state_d = ST_CAP_RIGHT;
      ST_CAP_RIGHT:  state_d = ST_GAIN_WAIT;
      ST_GAIN_WAIT: begin
        if (div_rsp.done) begin
          state_d = ST_MUL_LEFT;
        end
      end
      ST_MUL_LEFT:   state_d = ST_MUL_RIGHT;
      ST_MUL_RIGHT:  state_d = ST_FADE_RIGHT;
      ST_FADE_RIGHT: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:       state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    rd_right        = 1'b0;
    div_start       = 1'b0;
    emit            = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        mem_we          = in_acc && in_op == OP_LOAD;
        mem_re          = in_acc && in_op == OP_TICK && play_q;
        div_start       = mem_re;
      end
      ST_RD_RIGHT: begin
        mem_re   = 1'b1;
        rd_right = 1'b1;
      end
      ST_EMIT: emit = out_free;
      default: ;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      loop_start_q  <= '0;
      loop_end_q    <= '1;
      target_gain_q <= GAIN_W'(16384);
      chan_count_q  <= CC_W'(2);
      reverse_q     <= 1'b0;
      play_q        <= 1'b0;
      pos_q         <= '0;
      sg_q          <= '0;
      ramp_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_LOOP_START:  loop_start_q  <= cfg_data_i[POS_W-1:0];
          CFG_LOOP_END:    loop_end_q    <= cfg_data_i[POS_W-1:0];
          CFG_TARGET_GAIN: target_gain_q <= cfg_data_i[GAIN_W-1:0];
          CFG_CHAN_COUNT:  chan_count_q  <= cfg_data_i[CC_W-1:0];
          CFG_REVERSE:     reverse_q     <= cfg_data_i[0];
          CFG_PLAY_ENABLE: play_q        <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (state_q == ST_IDLE && in_acc && in_op == OP_SEEK) begin
        pos_q <= in_seek;
      end

      if (state_q == ST_GAIN_WAIT && div_rsp.done) begin
        sg_q <= sg_next;
      end

      // wrap jumps to the other loop point, otherwise the position steps and, in a fade window, the ramp moves
      if (state_q == ST_MUL_LEFT) begin
        if (past_end) begin
          pos_q <= loop_start_q;
        end else if (before_start) begin
          pos_q <= loop_end_q;
        end else begin
          pos_q <= pos_step;
          if (in_fade_in) begin
            if (ramp_q < RAMP_W'(RAMP_LENGTH)) begin
              ramp_q <= ramp_q + 1'b1;
            end
          end else if (in_fade_out) begin
            if (ramp_q != '0) begin
              ramp_q <= ramp_q - 1'b1;
            end
          end
        end
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc && in_op == OP_TICK && !play_q) begin
      lf_q   <= '0;
      rf_q   <= '0;
      wrap_q <= 1'b0;
    end
    if (state_q == ST_RD_RIGHT) begin
      lw_q <= mem_rdata;
    end
    if (state_q == ST_CAP_RIGHT) begin
      rw_q <= stereo ? mem_rdata : lw_q;
    end
    if (state_q == ST_MUL_LEFT) begin
      lv_q   <= scaled;
      wrap_q <= past_end || before_start;
      fade_q <= !past_end && !before_start && (in_fade_in || in_fade_out);
    end
    if (state_q == ST_MUL_RIGHT) begin
      rv_q <= scaled;
      lf_q <= fsat;
    end
    if (state_q == ST_FADE_RIGHT) begin
      rf_q <= fsat;
    end
    if (emit) begin
      out_l_q    <= lf_q;
      out_r_q    <= rf_q;
      out_wrap_q <= wrap_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_r_q, out_l_q};
  assign m_axis_tuser_o  = out_wrap_q;

endmodule

`default_nettype wire
